// ===== src/sle_pkg.sv =====
// Shared constants, codes and types of the sorted list engine.
`default_nettype none
package sle_pkg;

    localparam int unsigned CAPACITY = 16;
    localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
    localparam int unsigned IDX_W    = $clog2(CAPACITY);
    localparam int unsigned VAL_W    = 32;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic signed [VAL_W-1:0] val_t;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_DUMP   = 2'd2
    } req_code_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_code_t;

    typedef struct packed {
        logic ins;
        logic del;
        val_t v;
    } cell_op_t;

endpackage
`default_nettype wire

// ===== src/sle_if.sv =====
// Request and result channel interfaces of the sorted list engine.
`default_nettype none
interface sle_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic signed [31:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface sle_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] value_res;
    logic               last;

    modport source (output valid, output status, output value_res, output last, input ready);
    modport sink   (input valid, input status, input value_res, input last, output ready);
endinterface
`default_nettype wire

// ===== src/sle_cell.sv =====
// One storage cell of the sorted chain: compares and shifts with its neighbors.
`default_nettype none
module sle_cell (
    input  wire logic             clk,
    input  wire logic             occ,
    input  wire sle_pkg::cell_op_t op,
    input  wire sle_pkg::val_t    left_val,
    input  wire logic             left_lt,
    input  wire sle_pkg::val_t    right_val,
    input  wire logic             seen_in,
    output sle_pkg::val_t         val,
    output logic                  lt,
    output logic                  after
);

    sle_pkg::val_t val_reg;
    sle_pkg::val_t val_next;
    logic          eq;

    assign val   = val_reg;
    assign lt    = occ && (val_reg < op.v);
    assign eq    = occ && (val_reg == op.v);
    assign after = seen_in | eq;

    always_comb
    begin
        val_next = val_reg;
        if (op.ins)
        begin
            if (!lt)
            begin
                val_next = left_lt ? op.v : left_val;
            end
        end
        else if (op.del && after)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule
`default_nettype wire

// ===== src/sorted_list_engine.sv =====
// Sorted list engine: a chain of cells that keeps signed values in ascending order.
//
// Usage: requests enter on the req channel (req_type, value), results leave on
// the res channel (status, value_res, last); both use a valid/ready handshake.
// Insert and delete update every cell of the chain in the cycle the item is
// accepted and give one result, registered, in the next cycle. An insert goes
// ahead of equal values; a delete removes the first equal value.
// A dump gives one result per stored value in ascending order, read from the
// cells into the output register one per cycle while res is taken, last set on the final one;
// an empty store gives one result with status empty. Request code 3 is dropped.
// Throughput: one insert or delete per cycle while res is taken every cycle;
// a dump holds the request side until its last value is read out by the
// single read port that walks the cells. The request side stalls while a dump
// streams. When the receiver stalls, the result stays in the output register
// and the block takes no new request until that result is taken.
// Reset empties the store at once; cell contents are not cleared.
`default_nettype none
module sorted_list_engine (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sle_req_if.sink    req,
    sle_res_if.source  res
);

    localparam int unsigned N = sle_pkg::CAPACITY;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    sle_pkg::cnt_t count_reg, count_next;
    sle_pkg::idx_t idx_reg, idx_next;
    logic          res_valid_reg, res_valid_next;
    logic [1:0]    status_reg, status_next;
    sle_pkg::val_t value_reg, value_next;
    logic          last_reg, last_next;

    sle_pkg::cell_op_t op;
    sle_pkg::val_t     vals   [N];
    logic              lts    [N];
    logic              afters [N];

    logic out_free;
    logic acc;
    logic full;
    logic empty;
    logic found;
    logic dump_last;

    assign out_free  = !res_valid_reg || res.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign acc       = req.valid && req.ready;
    assign full      = (count_reg == sle_pkg::cnt_t'(N));
    assign empty     = (count_reg == '0);
    assign found     = afters[N-1];
    assign dump_last = (sle_pkg::cnt_t'(idx_reg) + sle_pkg::cnt_t'(1)) == count_reg;

    assign op.ins = acc && (req.req_type == sle_pkg::REQ_INSERT) && !full;
    assign op.del = acc && (req.req_type == sle_pkg::REQ_DELETE);
    assign op.v   = req.value;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        sle_pkg::val_t lval;
        sle_pkg::val_t rval;
        logic          llt;
        logic          lseen;
        logic          occ;

        assign occ = count_reg > sle_pkg::cnt_t'(i);
        if (i == 0)
        begin : g_first
            assign lval  = vals[0];
            assign llt   = 1'b1;
            assign lseen = 1'b0;
        end
        else
        begin : g_mid
            assign lval  = vals[i-1];
            assign llt   = lts[i-1];
            assign lseen = afters[i-1];
        end
        if (i == N - 1)
        begin : g_last
            assign rval = vals[i];
        end
        else
        begin : g_inner
            assign rval = vals[i+1];
        end

        sle_cell u_cell (
            .clk       (clk),
            .occ       (occ),
            .op        (op),
            .left_val  (lval),
            .left_lt   (llt),
            .right_val (rval),
            .seen_in   (lseen),
            .val       (vals[i]),
            .lt        (lts[i]),
            .after     (afters[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        res_valid_next = res_valid_reg && !res.ready;
        status_next    = status_reg;
        value_next     = value_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    unique case (req.req_type)
                        sle_pkg::REQ_INSERT:
                        begin
                            res_valid_next = 1'b1;
                            value_next     = '0;
                            last_next      = 1'b1;
                            status_next    = full ? sle_pkg::STAT_FULL : sle_pkg::STAT_OK;
                            if (!full)
                            begin
                                count_next = count_reg + sle_pkg::cnt_t'(1);
                            end
                        end
                        sle_pkg::REQ_DELETE:
                        begin
                            res_valid_next = 1'b1;
                            value_next     = '0;
                            last_next      = 1'b1;
                            if (empty)
                            begin
                                status_next = sle_pkg::STAT_EMPTY;
                            end
                            else if (found)
                            begin
                                status_next = sle_pkg::STAT_OK;
                                count_next  = count_reg - sle_pkg::cnt_t'(1);
                            end
                            else
                            begin
                                status_next = sle_pkg::STAT_NOT_FOUND;
                            end
                        end
                        sle_pkg::REQ_DUMP:
                        begin
                            if (empty)
                            begin
                                res_valid_next = 1'b1;
                                value_next     = '0;
                                last_next      = 1'b1;
                                status_next    = sle_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = ST_DUMP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    status_next    = sle_pkg::STAT_OK;
                    value_next     = vals[idx_reg];
                    last_next      = dump_last;
                    idx_next       = idx_reg + sle_pkg::idx_t'(1);
                    if (dump_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
    end

    assign res.valid     = res_valid_reg;
    assign res.status    = status_reg;
    assign res.value_res = value_reg;
    assign res.last      = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sle_pkg::cnt_t'(N))
        else $error("entry count above capacity");

    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> (count_reg != '0))
        else $error("dump running on an empty store");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && req.req_type == sle_pkg::REQ_INSERT && !full)
        |=> (count_reg == $past(count_reg) + sle_pkg::cnt_t'(1)))
        else $error("insert did not grow the store");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (state_reg == ST_IDLE && out_free))
        else $error("request taken outside idle");
`endif

endmodule
`default_nettype wire
